/* hw/rtl/tsp_pkg.sv */
package tsp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned StepW    = 32;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned PctW     = 8;
  localparam int unsigned ProdW    = SpeedW + PctW;

  // Division by 100 of a value below 2**ProdW as a multiply by ceil(2**31 / 100).
  // The rounding error of the reciprocal times the largest product stays below
  // 2**31, so the floor is exact.
  localparam int unsigned RecipShift = 31;
  localparam int unsigned RecipW     = 25;
  localparam logic [RecipW-1:0] RecipK = 25'd21474837;
  localparam int unsigned ScaledW    = ProdW + RecipW;
  localparam int unsigned QuotW      = ScaledW - RecipShift;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOTAL_STEPS    = 3'd0,
    CFG_START_SPEED    = 3'd1,
    CFG_PEAK_SPEED     = 3'd2,
    CFG_ACCEL_PER_STEP = 3'd3,
    CFG_SPEED_PERCENT  = 3'd4
  } cfg_reg_e;

  localparam logic [StepW-1:0]  RstTotalSteps  = 32'd1;
  localparam logic [SpeedW-1:0] RstStartSpeed  = 16'd50;
  localparam logic [SpeedW-1:0] RstPeakSpeed   = 16'd1000;
  localparam logic [SpeedW-1:0] RstAccelPerStep = 16'd1;
  localparam logic [PctW-1:0]   RstSpeedPercent = 8'd100;

  // Sanitized configuration as the datapath sees it.
  typedef struct packed {
    logic [StepW-1:0]  last_step;
    logic [SpeedW-1:0] start_speed;
    logic [SpeedW-1:0] peak_speed;
    logic [SpeedW-1:0] accel;
    logic [PctW-1:0]   percent;
    logic              ok;
  } cfg_t;

endpackage

/* hw/rtl/tsp_cfg.sv */
module tsp_cfg
  import tsp_pkg::*;
#(
  parameter int unsigned MAX_SPEED       = 4000,
  parameter int unsigned MIN_START_SPEED = 50,
  parameter int unsigned PERCENT_MIN     = 10,
  parameter int unsigned PERCENT_MAX     = 200
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] wdata_i,
  output cfg_t                cfg_o
);

  localparam logic [SpeedW-1:0] MaxSpeed  = SpeedW'(MAX_SPEED);
  localparam logic [SpeedW-1:0] MinStart  = SpeedW'(MIN_START_SPEED);
  localparam logic [PctW-1:0]   PctMin    = PctW'(PERCENT_MIN);
  localparam logic [PctW-1:0]   PctMax    = PctW'(PERCENT_MAX);

  logic [StepW-1:0]  total_steps_q;
  logic [SpeedW-1:0] start_speed_q;
  logic [SpeedW-1:0] peak_speed_q;
  logic [SpeedW-1:0] accel_q;
  logic [PctW-1:0]   percent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_steps_q <= RstTotalSteps;
      start_speed_q <= RstStartSpeed;
      peak_speed_q  <= RstPeakSpeed;
      accel_q       <= RstAccelPerStep;
      percent_q     <= RstSpeedPercent;
    end else if (we_i) begin
      unique case (cfg_reg_e'(idx_i))
        CFG_TOTAL_STEPS:    total_steps_q <= wdata_i[StepW-1:0];
        CFG_START_SPEED:    start_speed_q <= wdata_i[SpeedW-1:0];
        CFG_PEAK_SPEED:     peak_speed_q  <= wdata_i[SpeedW-1:0];
        CFG_ACCEL_PER_STEP: accel_q       <= wdata_i[SpeedW-1:0];
        CFG_SPEED_PERCENT:  percent_q     <= wdata_i[PctW-1:0];
        default: ;
      endcase
    end
  end

  // Corrections go in this order: the start floor, then the ceiling,
  // then the peak is capped and raised to the start.
  logic [SpeedW-1:0] vmin_floor;
  logic [SpeedW-1:0] vmin;
  logic [SpeedW-1:0] vpk_cap;
  logic [SpeedW-1:0] vpk;
  logic [PctW-1:0]   pct_lo;
  logic              bad_steps, bad_floor, bad_ceil, bad_peak, bad_order;
  logic              bad_accel, bad_pct;

  always_comb begin
    bad_steps  = (total_steps_q == '0);
    bad_floor  = (start_speed_q < MinStart);
    vmin_floor = bad_floor ? MinStart : start_speed_q;
    bad_ceil   = (vmin_floor > MaxSpeed);
    vmin       = bad_ceil ? MaxSpeed : vmin_floor;
    bad_peak   = (peak_speed_q > MaxSpeed);
    vpk_cap    = bad_peak ? MaxSpeed : peak_speed_q;
    bad_order  = (vmin > vpk_cap);
    vpk        = bad_order ? vmin : vpk_cap;
    bad_accel  = (accel_q == '0);
    bad_pct    = (percent_q < PctMin) || (percent_q > PctMax);
    pct_lo     = (percent_q < PctMin) ? PctMin : percent_q;

    cfg_o.last_step   = bad_steps ? '0 : total_steps_q - StepW'(1);
    cfg_o.start_speed = vmin;
    cfg_o.peak_speed  = vpk;
    cfg_o.accel       = bad_accel ? SpeedW'(1) : accel_q;
    cfg_o.percent     = (pct_lo > PctMax) ? PctMax : pct_lo;
    cfg_o.ok          = !(bad_steps || bad_floor || bad_ceil || bad_peak ||
                          bad_order || bad_accel || bad_pct);
  end

endmodule

/* hw/rtl/tsp_pipe.sv */
module tsp_pipe
  import tsp_pkg::*;
#(
  parameter int unsigned MAX_SPEED = 4000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [StepW-1:0]  step_index_i,
  input  cfg_t              cfg_i,
  output logic              valid_o,
  output logic [SpeedW-1:0] speed_o,
  output logic              ok_o
);

  localparam logic [SpeedW-1:0] MaxSpeed = SpeedW'(MAX_SPEED);
  localparam int unsigned RampW = StepW + SpeedW;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Stage 1: index clamp and distance from the last step.
  logic [StepW-1:0]  s1_idx_q, s1_dn_q;
  logic [SpeedW-1:0] s1_vmin_q, s1_vpk_q, s1_acc_q;
  logic [PctW-1:0]   s1_pct_q;
  logic              s1_ok_q;
  logic              past_end;

  // Stage 2: peak times percent, and both ramp products.
  logic [ProdW-1:0]  s2_prod_q;
  logic [RampW-1:0]  s2_up_q, s2_dn_q;
  logic [SpeedW-1:0] s2_vmin_q;
  logic              s2_ok_q;

  // Stage 3: reciprocal multiply for the division by 100.
  logic [ScaledW-1:0] s3_scaled_q;
  logic [RampW-1:0]   s3_up_q, s3_dn_q;
  logic [SpeedW-1:0]  s3_vmin_q;
  logic               s3_ok_q;

  // Stage 4: plateau speed and ramp height.
  logic [QuotW-1:0]  quot;
  logic [SpeedW-1:0] cap, top;
  logic [SpeedW-1:0] s4_top_q, s4_room_q, s4_vmin_q;
  logic [RampW-1:0]  s4_up_q, s4_dn_q;
  logic              s4_ok_q;

  // Stage 5: ramp saturation and the lower of the two ramps.
  logic [SpeedW-1:0] up_spd, dn_spd;
  logic [SpeedW-1:0] s5_speed_q;
  logic              s5_ok_q;

  assign past_end = (step_index_i > cfg_i.last_step);

  always_comb begin
    quot = s3_scaled_q[ScaledW-1:RecipShift];
    cap  = (quot > QuotW'(MaxSpeed)) ? MaxSpeed : quot[SpeedW-1:0];
    top  = (cap < s3_vmin_q) ? s3_vmin_q : cap;
    top  = (top > MaxSpeed) ? MaxSpeed : top;
  end

  // A ramp reaches the plateau once index * accel covers the room.
  always_comb begin
    up_spd = (s4_up_q >= RampW'(s4_room_q)) ? s4_top_q : s4_vmin_q + s4_up_q[SpeedW-1:0];
    dn_spd = (s4_dn_q >= RampW'(s4_room_q)) ? s4_top_q : s4_vmin_q + s4_dn_q[SpeedW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= past_end ? cfg_i.last_step : step_index_i;
    s1_dn_q   <= past_end ? '0 : cfg_i.last_step - step_index_i;
    s1_vmin_q <= cfg_i.start_speed;
    s1_vpk_q  <= cfg_i.peak_speed;
    s1_acc_q  <= cfg_i.accel;
    s1_pct_q  <= cfg_i.percent;
    s1_ok_q   <= cfg_i.ok;

    s2_prod_q <= s1_vpk_q * s1_pct_q;
    s2_up_q   <= s1_idx_q * s1_acc_q;
    s2_dn_q   <= s1_dn_q * s1_acc_q;
    s2_vmin_q <= s1_vmin_q;
    s2_ok_q   <= s1_ok_q;

    s3_scaled_q <= s2_prod_q * RecipK;
    s3_up_q     <= s2_up_q;
    s3_dn_q     <= s2_dn_q;
    s3_vmin_q   <= s2_vmin_q;
    s3_ok_q     <= s2_ok_q;

    s4_top_q  <= top;
    s4_room_q <= top - s3_vmin_q;
    s4_vmin_q <= s3_vmin_q;
    s4_up_q   <= s3_up_q;
    s4_dn_q   <= s3_dn_q;
    s4_ok_q   <= s3_ok_q;

    s5_speed_q <= (up_spd < dn_spd) ? up_spd : dn_spd;
    s5_ok_q    <= s4_ok_q;
  end

  assign valid_o = v5_q;
  assign speed_o = s5_speed_q;
  assign ok_o    = s5_ok_q;

endmodule

/* hw/rtl/trapezoid_speed_profile.sv */
// Channel   Direction  Handshake            Payload
// command   in         start_i, busy_o      step_index_i
// result    out        done_o (strobe)      speed_o, settings_ok_o
// config    in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// A command beat is taken at every edge where start_i is high and busy_o low;
// busy_o stays low, so one beat can enter every cycle.
// Each result appears on done_o for one cycle, in command order. The five
// register stages are the index clamp, the ramp and percent products, the
// reciprocal multiply, the plateau speed and the lower of the two ramps.
// Reset clears the stage valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module trapezoid_speed_profile
  import tsp_pkg::*;
#(
  parameter int unsigned MAX_SPEED       = 4000,
  parameter int unsigned MIN_START_SPEED = 50,
  parameter int unsigned PERCENT_MIN     = 10,
  parameter int unsigned PERCENT_MAX     = 200
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [StepW-1:0]    step_index_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                done_o,
  output logic [SpeedW-1:0]   speed_o,
  output logic                settings_ok_o
);

  cfg_t cfg;

  // The configuration is sanitized combinationally from the registers, so a
  // command beat right after a write already sees the new values. The user must
  // change registers only while no beat is in flight; the block does not check.
  tsp_cfg #(
    .MAX_SPEED       (MAX_SPEED),
    .MIN_START_SPEED (MIN_START_SPEED),
    .PERCENT_MIN     (PERCENT_MIN),
    .PERCENT_MAX     (PERCENT_MAX)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Every stage advances each cycle, so the block is never busy.
  assign busy_o = 1'b0;

  tsp_pipe #(
    .MAX_SPEED (MAX_SPEED)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start_i && !busy_o),
    .step_index_i (step_index_i),
    .cfg_i        (cfg),
    .valid_o      (done_o),
    .speed_o      (speed_o),
    .ok_o         (settings_ok_o)
  );

endmodule

/* hw/rtl/tsp_checker.sv */
module tsp_checker #(
  parameter int unsigned MAX_SPEED       = 4000,
  parameter int unsigned MIN_START_SPEED = 50
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [15:0] speed_o
);

  localparam logic [15:0] MaxSpeed = 16'(MAX_SPEED);
  localparam logic [15:0] MinStart = 16'(MIN_START_SPEED);
  localparam logic [15:0] Floor    = (MinStart < MaxSpeed) ? MinStart : MaxSpeed;

  // Every command beat yields its result on done_o.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##5 done_o)
    else $error("result missing five cycles after a command beat");

  // No result appears without a matching earlier command beat.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 5))
    else $error("result without a matching command beat");

  // The commanded speed lies between the start floor and the speed ceiling.
  a_speed_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (speed_o <= MaxSpeed) && (speed_o >= Floor))
    else $error("speed outside the allowed range");

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

endmodule

bind trapezoid_speed_profile tsp_checker #(
  .MAX_SPEED       (MAX_SPEED),
  .MIN_START_SPEED (MIN_START_SPEED)
) u_tsp_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .speed_o (speed_o)
);
